### rtl/mbrr_pkg.sv
package mbrr_pkg;

  // Operation codes carried by an incoming request.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CRC     = 2'd2;
  localparam logic [1:0] ST_FUNC    = 2'd3;

  // Result kinds.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SLAVE   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  // Configuration reset values.
  localparam logic [7:0]  SLAVE_RESET   = 8'h15;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // Protocol constants.
  localparam logic [7:0]  FUNC_READ = 8'h03;
  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;

  // Response byte positions.
  localparam logic [2:0] RX_FUNC   = 3'd1;
  localparam logic [2:0] RX_VAL_HI = 3'd3;
  localparam logic [2:0] RX_VAL_LO = 3'd4;
  localparam logic [2:0] RX_CRC_LO = 3'd5;
  localparam logic [2:0] RX_LAST   = 3'd6;

  // Request frame byte positions.
  localparam logic [2:0] TX_SLAVE   = 3'd0;
  localparam logic [2:0] TX_FUNC    = 3'd1;
  localparam logic [2:0] TX_ADDR_HI = 3'd2;
  localparam logic [2:0] TX_ADDR_LO = 3'd3;
  localparam logic [2:0] TX_CNT_HI  = 3'd4;
  localparam logic [2:0] TX_CNT_LO  = 3'd5;
  localparam logic [2:0] TX_CRC_LO  = 3'd6;
  localparam logic [2:0] TX_CRC_HI  = 3'd7;

  // Default depth of the job queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // One job handed from the front to the back.
  typedef struct packed {
    logic               report;
    logic [1:0]         status;
    logic signed [15:0] value;
    logic [7:0]         slave;
    logic [15:0]        reg_addr;
  } job_t;

  typedef enum logic {
    B_IDLE,
    B_SEND
  } back_state_t;

  // One byte of the reflected CRC-16 update.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/mbrr_intf.sv
// Incoming request channel.
interface mbrr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] register_address;
  logic [7:0]  rx_byte;

  modport source(output valid, operation, register_address, rx_byte, input ready);
  modport sink(input valid, operation, register_address, rx_byte, output ready);
endinterface

// Result channel.
interface mbrr_rsp_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         tx_byte;
  logic               last_byte;
  logic [1:0]         status;
  logic signed [15:0] value_tenths;

  modport source(output valid, kind, tx_byte, last_byte, status, value_tenths, input ready);
  modport sink(input valid, kind, tx_byte, last_byte, status, value_tenths, output ready);
endinterface

// Configuration write channel.
interface mbrr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/mbrr_front.sv
module mbrr_front
  import mbrr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mbrr_cmd_if.sink      cmd,
  mbrr_cfg_if.sink      cfg,
  output logic          push,
  output job_t          job,
  input  logic          full
);

  logic [7:0]  slave_address;
  logic [15:0] timeout_ticks;
  logic        busy, busy_next;
  logic [2:0]  rx_count, rx_count_next;
  logic [15:0] elapsed, elapsed_next;
  logic [15:0] crc_run, crc_run_next;
  logic [7:0]  func_byte;
  logic [7:0]  val_hi;
  logic [7:0]  val_lo;
  logic [7:0]  crc_lo;

  logic        accept;
  logic        byte_take;
  logic [15:0] tick_inc;
  logic [15:0] crc_calc;
  logic [15:0] crc_recv;

  assign cmd.ready = !full;
  assign cfg.ready = 1'b1;
  assign accept    = cmd.valid && cmd.ready;
  assign byte_take = accept && busy && (cmd.operation == OP_BYTE);
  assign tick_inc  = (elapsed == TICK_MAX) ? elapsed : elapsed + 16'd1;
  assign crc_calc  = crc_byte(crc_run, cmd.rx_byte);
  assign crc_recv  = {cmd.rx_byte, crc_lo};

  // Classify each request and build the job it causes, if any.
  always_comb begin
    push          = 1'b0;
    job           = '0;
    busy_next     = busy;
    rx_count_next = rx_count;
    elapsed_next  = elapsed;
    crc_run_next  = crc_run;
    if (accept) begin
      unique case (cmd.operation)
        OP_START: begin
          if (!busy) begin
            push          = 1'b1;
            job.report    = 1'b0;
            job.slave     = slave_address;
            job.reg_addr  = cmd.register_address;
            busy_next     = 1'b1;
            rx_count_next = 3'd0;
            elapsed_next  = 16'd0;
            crc_run_next  = CRC_SEED;
          end
        end
        OP_BYTE: begin
          if (busy) begin
            // The running CRC covers the response bytes before the two CRC bytes.
            if (rx_count < RX_CRC_LO) begin
              crc_run_next = crc_calc;
            end
            if (rx_count == RX_LAST) begin
              push          = 1'b1;
              job.report    = 1'b1;
              busy_next     = 1'b0;
              rx_count_next = 3'd0;
              priority if (crc_recv != crc_run) begin
                job.status = ST_CRC;
              end else if (func_byte != FUNC_READ) begin
                job.status = ST_FUNC;
              end else begin
                job.status = ST_OK;
                job.value  = {val_hi, val_lo};
              end
            end else begin
              rx_count_next = rx_count + 3'd1;
            end
          end
        end
        OP_TICK: begin
          if (busy) begin
            elapsed_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              push          = 1'b1;
              job.report    = 1'b1;
              job.status    = ST_TIMEOUT;
              busy_next     = 1'b0;
              rx_count_next = 3'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Transaction state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rx_count <= 3'd0;
      elapsed  <= 16'd0;
    end else begin
      busy     <= busy_next;
      rx_count <= rx_count_next;
      elapsed  <= elapsed_next;
    end
  end

  // Running CRC and the response bytes that the report needs.
  always_ff @(posedge clk) begin
    crc_run <= crc_run_next;
    if (byte_take) begin
      if (rx_count == RX_FUNC) begin
        func_byte <= cmd.rx_byte;
      end
      if (rx_count == RX_VAL_HI) begin
        val_hi <= cmd.rx_byte;
      end
      if (rx_count == RX_VAL_LO) begin
        val_lo <= cmd.rx_byte;
      end
      if (rx_count == RX_CRC_LO) begin
        crc_lo <= cmd.rx_byte;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SLAVE:   slave_address <= cfg.data[7:0];
        REG_TIMEOUT: timeout_ticks <= cfg.data;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The response count never runs past the last response byte.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rx_count <= RX_LAST)
    else $error("response byte count out of range");
`endif

endmodule

### rtl/mbrr_queue.sv
module mbrr_queue
  import mbrr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("job queue underflow");
`endif

endmodule

### rtl/mbrr_back.sv
module mbrr_back
  import mbrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  mbrr_rsp_if.source rsp
);

  back_state_t state, state_next;
  logic [2:0]  idx, idx_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  job_slave;
  logic [15:0] job_addr;

  logic               slot_free;
  logic               load;
  logic               latch_job;
  logic               o_kind;
  logic [7:0]         o_tx;
  logic               o_last;
  logic [1:0]         o_status;
  logic signed [15:0] o_value;
  logic [7:0]         frame_byte;
  logic [15:0]        crc_in;
  logic [7:0]         crc_data;
  logic [15:0]        crc_upd;

  assign slot_free = !rsp.valid || rsp.ready;

  // Request frame byte at the current position.
  always_comb begin
    unique case (idx)
      TX_SLAVE:   frame_byte = job_slave;
      TX_FUNC:    frame_byte = FUNC_READ;
      TX_ADDR_HI: frame_byte = job_addr[15:8];
      TX_ADDR_LO: frame_byte = job_addr[7:0];
      TX_CNT_HI:  frame_byte = 8'h00;
      TX_CNT_LO:  frame_byte = 8'h01;
      TX_CRC_LO:  frame_byte = crc[7:0];
      TX_CRC_HI:  frame_byte = crc[15:8];
    endcase
  end

  // One shared CRC step: the first byte starts from the seed.
  assign crc_in   = (state == B_IDLE) ? CRC_SEED : crc;
  assign crc_data = (state == B_IDLE) ? head.slave : frame_byte;
  assign crc_upd  = crc_byte(crc_in, crc_data);

  // Sequencer: take a job; frame bytes go one a cycle unless rsp stalls.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    crc_next   = crc;
    pop        = 1'b0;
    load       = 1'b0;
    latch_job  = 1'b0;
    o_kind     = KIND_BYTE;
    o_tx       = 8'h00;
    o_last     = 1'b0;
    o_status   = ST_OK;
    o_value    = '0;
    unique case (state)
      B_IDLE: begin
        if (!empty && slot_free) begin
          pop  = 1'b1;
          load = 1'b1;
          if (head.report) begin
            o_kind   = KIND_REPORT;
            o_status = head.status;
            o_value  = head.value;
          end else begin
            o_tx       = head.slave;
            crc_next   = crc_upd;
            idx_next   = TX_FUNC;
            latch_job  = 1'b1;
            state_next = B_SEND;
          end
        end
      end
      B_SEND: begin
        if (slot_free) begin
          load = 1'b1;
          o_tx = frame_byte;
          if (idx < TX_CRC_LO) begin
            crc_next = crc_upd;
          end
          if (idx == TX_CRC_HI) begin
            o_last     = 1'b1;
            idx_next   = TX_SLAVE;
            state_next = B_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= TX_SLAVE;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Frame working registers.
  always_ff @(posedge clk) begin
    crc <= crc_next;
    if (latch_job) begin
      job_slave <= head.slave;
      job_addr  <= head.reg_addr;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.kind         <= o_kind;
      rsp.tx_byte      <= o_tx;
      rsp.last_byte    <= o_last;
      rsp.status       <= o_status;
      rsp.value_tenths <= o_value;
    end
  end

`ifndef SYNTHESIS
  a_last_is_byte: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last_byte) |-> (rsp.kind == KIND_BYTE))
    else $error("last-byte mark on a completion report");
  a_send_past_first: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEND) |-> (idx != TX_SLAVE))
    else $error("frame position restarted while sending");
`endif

endmodule

### rtl/modbus_rtu_register_read_master.sv
// Channel  Direction  Contents
// cmd      in         operation, register_address, rx_byte (valid/ready)
// rsp      out        kind, tx_byte, last_byte, status, value_tenths (valid/ready)
// cfg      in         index, data: 0 slave address, 1 timeout ticks (valid/ready)
//
// The front takes one request every cycle while the job queue has room.
// A start yields eight frame bytes, one CRC byte step per cycle in the back
// sequencer unless rsp stalls; a report goes via the queue and output register.
// Reset (rst, synchronous) returns to idle with default configuration.
// A stall on rsp fills the job queue; cmd stalls only when the queue is full.
module modbus_rtu_register_read_master
  import mbrr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mbrr_cmd_if.sink   cmd,
  mbrr_cfg_if.sink   cfg,
  mbrr_rsp_if.source rsp
);

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  job_t head_job;
  logic empty;

  // Front: classify requests and track the transaction.
  mbrr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .cfg  (cfg),
    .push (push),
    .job  (push_job),
    .full (full)
  );

  // Job queue between front and back.
  mbrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_job),
    .empty     (empty)
  );

  // Back: emit frame bytes and reports.
  mbrr_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head_job),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule
